// ===== hdl/mm3_pkg.sv =====
// Shared types, constants and mixing functions for the 128-bit hash block.
package mm3_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] lanes_t;

	// One word as it travels from the front to the back through the queue.
	typedef struct packed {
		word_t      k;
		logic [2:0] count;
		logic       last;
		logic [1:0] pos;
	} mm3_word_t;

	localparam lanes_t LANE_MUL = {32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789, 32'h239b961b};
	localparam lanes_t LANE_ADD = {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};
	localparam logic [3:0][4:0] MIX_ROT  = {5'd18, 5'd17, 5'd16, 5'd15};
	localparam logic [3:0][4:0] STEP_ROT = {5'd13, 5'd15, 5'd17, 5'd19};
	localparam word_t FMIX_C1 = 32'h85ebca6b;
	localparam word_t FMIX_C2 = 32'hc2b2ae35;
	localparam logic [2:0] FULL_COUNT = 3'd4;
	localparam logic [1:0] LAST_POS = 2'd3;

	function automatic word_t rotl32(word_t x, logic [4:0] r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

	// Rotate, add neighbor, times five plus lane constant, on all four lanes.
	// Lanes update in order, so lane four adds the already updated lane one.
	function automatic lanes_t block_step(lanes_t h, lanes_t k);
		lanes_t r;
		word_t  t;
		for (int i = 0; i < 4; i++) begin
			t = rotl32(h[i] ^ k[i], STEP_ROT[i]) + ((i == 3) ? r[0] : h[2'(i + 1)]);
			r[i] = (t << 2) + t + LANE_ADD[i];
		end
		return r;
	endfunction

endpackage

// ===== hdl/murmur3_x86_128_hash.sv =====
// Top level of the 128-bit streaming hash: front, word queue and back.
//
//  channel | direction | handshake           | payload
//  in      | to block  | in_valid/in_ready   | data_word, byte_count, last
//  out     | from block| out_valid/out_ready | hash_word0..hash_word3
//  seed    | to block  | seed_we             | seed_wdata
//
// The front takes one word per cycle unless the queue stalls it; it registers the masked
// word, then the first multiply, then the rotate and second multiply. The back retires
// one word per cycle outside finalize, which a last word adds (sum, two multiply rounds,
// output sum). Reset clears the seed to zero and starts the next item on a new message.
// The queue lets the front keep taking words while the back finalizes or the result waits.
module murmur3_x86_128_hash #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_word0,
	output logic [31:0] hash_word1,
	output logic [31:0] hash_word2,
	output logic [31:0] hash_word3
);

	localparam int QW = $bits(mm3_pkg::mm3_word_t);

	logic f_valid, f_ready, b_valid, b_pop;
	mm3_pkg::mm3_word_t f_word, b_word;
	logic [QW-1:0] b_raw;

	mm3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_word (data_word),
		.byte_count(byte_count),
		.last      (last),
		.q_valid   (f_valid),
		.q_ready   (f_ready),
		.q_word    (f_word)
	);

	mm3_fifo #(
		.WIDTH(QW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_valid),
		.push_ready(f_ready),
		.wdata     (f_word),
		.pop_valid (b_valid),
		.pop       (b_pop),
		.rdata     (b_raw)
	);

	assign b_word = mm3_pkg::mm3_word_t'(b_raw);

	mm3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata),
		.q_valid   (b_valid),
		.q_pop     (b_pop),
		.q_word    (b_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash_word0(hash_word0),
		.hash_word1(hash_word1),
		.hash_word2(hash_word2),
		.hash_word3(hash_word3)
	);

endmodule

// ===== hdl/mm3_front.sv =====
// Front: accepts words, masks and classifies them, and mixes each by its lane constants.
module mm3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       data_word,
	input  logic [2:0]        byte_count,
	input  logic              last,
	output logic              q_valid,
	input  logic              q_ready,
	output mm3_pkg::mm3_word_t q_word
);

	logic v_s1, v_s2, v_s3;
	logic [1:0] pos_q;
	mm3_pkg::mm3_word_t e_s1, e_s2, e_s3;
	logic advance, take, keep;
	logic [2:0] cnt;
	mm3_pkg::word_t masked;

	assign advance  = !v_s3 || q_ready;
	assign in_ready = advance;
	assign take     = in_valid && advance;
	assign cnt      = (byte_count > mm3_pkg::FULL_COUNT) ? mm3_pkg::FULL_COUNT : byte_count;
	// drop empty words that do not end a message
	assign keep     = take && (last || cnt != 3'd0);

	always_comb begin
		unique case (cnt)
			3'd0:    masked = 32'h0;
			3'd1:    masked = {24'h0, data_word[7:0]};
			3'd2:    masked = {16'h0, data_word[15:0]};
			3'd3:    masked = {8'h0, data_word[23:0]};
			default: masked = data_word;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			pos_q <= 2'd0;
		end else begin
			if (advance) begin
				v_s1 <= keep;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (keep) begin
				pos_q <= last ? 2'd0 : pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			e_s1 <= '{k: masked, count: cnt, last: last, pos: pos_q};
			e_s2 <= '{k: e_s1.k * mm3_pkg::LANE_MUL[e_s1.pos], count: e_s1.count,
				last: e_s1.last, pos: e_s1.pos};
			e_s3 <= '{k: mm3_pkg::rotl32(e_s2.k, mm3_pkg::MIX_ROT[e_s2.pos])
				* mm3_pkg::LANE_MUL[e_s2.pos + 2'd1], count: e_s2.count,
				last: e_s2.last, pos: e_s2.pos};
		end
	end

	assign q_valid = v_s3;
	assign q_word  = e_s3;

endmodule

// ===== hdl/mm3_fifo.sv =====
// Small word queue between the front and the back.
module mm3_fifo #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  logic [WIDTH-1:0] wdata,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/mm3_back.sv =====
// Back: lane state update per word, then the finalization mix and the result register.
module mm3_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_we,
	input  logic [31:0]        seed_wdata,
	input  logic               q_valid,
	output logic               q_pop,
	input  mm3_pkg::mm3_word_t q_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        hash_word0,
	output logic [31:0]        hash_word1,
	output logic [31:0]        hash_word2,
	output logic [31:0]        hash_word3
);

	typedef enum logic [4:0] {
		ST_WORD = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_MUL1 = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;
	mm3_pkg::word_t seed_q, total_q, new_total, base_total, sum;
	logic in_msg_q;
	mm3_pkg::lanes_t lane_q, f_q, hash_q;
	mm3_pkg::word_t pend_q [3];
	logic out_valid_q, load_out;
	mm3_pkg::lanes_t base_lane, step, xl, fin_lane, g, s_lane, m1, m2, done_h;

	assign q_pop      = (state_q == ST_WORD) && q_valid;
	assign base_lane  = in_msg_q ? lane_q : {4{seed_q}};
	assign base_total = in_msg_q ? total_q : 32'h0;
	assign new_total  = base_total + {29'h0, q_word.count};
	assign step = mm3_pkg::block_step(base_lane, {q_word.k, pend_q[2], pend_q[1], pend_q[0]});

	always_comb begin
		// incomplete final block: XOR held words and the current word into their lanes
		for (int i = 0; i < 4; i++) begin
			xl[i] = base_lane[i];
			if (i < 3 && 2'(i) < q_word.pos) begin
				xl[i] = xl[i] ^ pend_q[(i < 3) ? i : 0];
			end
			if (2'(i) == q_word.pos && q_word.count != 3'd0) begin
				xl[i] = xl[i] ^ q_word.k;
			end
		end
		fin_lane = (q_word.count == mm3_pkg::FULL_COUNT && q_word.pos == mm3_pkg::LAST_POS)
			? step : xl;
	end

	always_comb begin
		sum = f_q[0] + f_q[1] + f_q[2] + f_q[3];
		for (int i = 0; i < 4; i++) begin
			s_lane[i] = (i == 0) ? sum : f_q[i] + sum;
			m1[i] = (f_q[i] ^ (f_q[i] >> 16)) * mm3_pkg::FMIX_C1;
			m2[i] = (f_q[i] ^ (f_q[i] >> 13)) * mm3_pkg::FMIX_C2;
			g[i]  = f_q[i] ^ (f_q[i] >> 16);
		end
		for (int i = 0; i < 4; i++) begin
			done_h[i] = (i == 0) ? g[0] + g[1] + g[2] + g[3]
				: g[i] + g[0] + g[1] + g[2] + g[3];
		end
	end

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WORD;
			seed_q      <= 32'h0;
			in_msg_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_WORD: begin
					if (q_pop) begin
						in_msg_q <= !q_word.last;
						if (q_word.last) begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_SUM:  state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_WORD;
					end
				end
				default: state_q <= ST_WORD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_WORD: begin
				if (q_pop) begin
					total_q <= new_total;
					if (q_word.last) begin
						for (int i = 0; i < 4; i++) begin
							f_q[i] <= fin_lane[i] ^ new_total;
						end
					end else if (q_word.pos == mm3_pkg::LAST_POS) begin
						lane_q <= step;
					end else begin
						lane_q <= base_lane;
						pend_q[q_word.pos[1] ? 2 : (q_word.pos[0] ? 1 : 0)] <= q_word.k;
					end
				end
			end
			ST_SUM:  f_q <= s_lane;
			ST_MUL1: f_q <= m1;
			ST_MUL2: f_q <= m2;
			ST_DONE: begin
				if (load_out) begin
					hash_q <= done_h;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign hash_word0 = hash_q[0];
	assign hash_word1 = hash_q[1];
	assign hash_word2 = hash_q[2];
	assign hash_word3 = hash_q[3];

endmodule

// ===== hdl/mm3_chk.sv =====
// Port-level checks for the hash block and their binding to the top level.
module mm3_chk #(
	parameter int FIFO_DEPTH = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] data_word,
	input logic [2:0]  byte_count,
	input logic        last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash_word0,
	input logic [31:0] hash_word1,
	input logic [31:0] hash_word2,
	input logic [31:0] hash_word3
);

	// messages ended at the input and not yet delivered
	localparam logic [15:0] MAX_OPEN = 16'(FIFO_DEPTH + 5);
	logic [15:0] open_q;
	logic end_in, end_out;

	assign end_in  = in_valid && in_ready && last;
	assign end_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 16'h0;
		end else if (end_in && !end_out) begin
			open_q <= open_q + 16'h1;
		end else if (end_out && !end_in) begin
			open_q <= open_q - 16'h1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_word) && $stable(byte_count)
			&& $stable(last))
		else $error("input word changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hash_word0) && $stable(hash_word1)
			&& $stable(hash_word2) && $stable(hash_word3))
		else $error("result changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 16'h0)
		else $error("result without an ended message");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= MAX_OPEN)
		else $error("more messages in flight than the block can hold");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result shown out of reset");

endmodule

bind murmur3_x86_128_hash mm3_chk #(.FIFO_DEPTH(FIFO_DEPTH)) u_mm3_chk (.*);

// ===== tb/murmur3_x86_128_hash_tb.sv =====
// Self-checking testbench for the streaming 128-bit MurmurHash3 x86 block.
`timescale 1ns / 100ps

module murmur3_x86_128_hash_tb;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] hash_t;

	typedef struct packed {
		word_t      data;
		logic [2:0] count;
		logic       fin;
	} msg_word_t;

	// Who stalls: the sink mostly, the source mostly, or nobody.
	typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FREE} pace_t;

	localparam logic [3:0][31:0] K_MUL = {32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789, 32'h239b961b};
	localparam logic [3:0][31:0] K_ADD = {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};
	localparam int MIX_R [4] = '{15, 16, 17, 18};
	localparam int STEP_R [4] = '{19, 17, 15, 13};
	localparam word_t AVAL_C1 = 32'h85ebca6b;
	localparam word_t AVAL_C2 = 32'hc2b2ae35;
	localparam int DRAIN = 24;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_WORDS = 275;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_we = 1'b0;
	logic [31:0] seed_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash_word0, hash_word1, hash_word2, hash_word3;

	// Hash state mirrored from the accepted word stream.
	word_t       seed_val = '0;
	hash_t       lane_h = '0;
	word_t       held_k [3];
	logic [1:0]  word_slot = '0;
	word_t       byte_sum = '0;
	logic        mid_msg = 1'b0;

	msg_word_t   words_todo [$];
	hash_t       hashes_due [$];
	msg_word_t   on_bus;
	hash_t       got_hash, want_hash;
	pace_t       pace = PACE_SLOW_SINK;
	int          fail_count = 0;
	int          words_taken = 0;
	int          hashes_seen = 0;
	int          seeds_written = 0;
	int          phase_items = 0;
	int          quiet = 0;

	murmur3_x86_128_hash i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_word0 (hash_word0),
		.hash_word1 (hash_word1),
		.hash_word2 (hash_word2),
		.hash_word3 (hash_word3)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic word_t rol(word_t x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic word_t lane_mix(word_t w, int lane);
		word_t k;
		k = w * K_MUL[lane];
		k = rol(k, MIX_R[lane]);
		k = k * K_MUL[(lane + 1) % 4];
		return k;
	endfunction

	function automatic word_t avalanche(word_t h);
		word_t v;
		v = h ^ (h >> 16);
		v = v * AVAL_C1;
		v = v ^ (v >> 13);
		v = v * AVAL_C2;
		v = v ^ (v >> 16);
		return v;
	endfunction

	// Lanes update in order, so lane four adds the already updated lane one.
	task lane_round(input word_t k3);
		word_t kk [4];
		word_t h;
		kk[0] = held_k[0];
		kk[1] = held_k[1];
		kk[2] = held_k[2];
		kk[3] = k3;
		for (int i = 0; i < 4; i++) begin
			h = rol(lane_h[i] ^ kk[i], STEP_R[i]) + lane_h[(i + 1) % 4];
			lane_h[i] = h * 5 + K_ADD[i];
		end
	endtask

	function automatic hash_t fold_lanes(hash_t h);
		hash_t r;
		r = h;
		r[0] = r[0] + r[1] + r[2] + r[3];
		r[1] = r[1] + r[0];
		r[2] = r[2] + r[0];
		r[3] = r[3] + r[0];
		return r;
	endfunction

	// Advance the mirrored hash by one accepted word; queue the digest on a last word.
	task absorb_word(input msg_word_t it);
		word_t      w;
		logic [2:0] n;
		int         p;
		hash_t      f;
		n = (it.count > 3'd4) ? 3'd4 : it.count;
		if (!it.fin && n == 3'd0)
			return;
		if (!mid_msg) begin
			for (int i = 0; i < 4; i++)
				lane_h[i] = seed_val;
			word_slot = '0;
			byte_sum = '0;
			mid_msg = 1'b1;
		end
		w = it.data;
		if (n < 3'd4)
			w = w & ((32'h1 << (8 * n)) - 32'h1);
		byte_sum = byte_sum + 32'(n);
		p = int'(word_slot);
		if (!it.fin) begin
			if (p == 3)
				lane_round(lane_mix(w, 3));
			else
				held_k[p] = lane_mix(w, p);
			word_slot = word_slot + 2'd1;
			return;
		end
		if (n == 3'd4 && p == 3) begin
			lane_round(lane_mix(w, 3));
		end else begin
			for (int i = 0; i < p; i++)
				lane_h[i] = lane_h[i] ^ held_k[i];
			if (n != 3'd0)
				lane_h[p] = lane_h[p] ^ lane_mix(w, p);
		end
		for (int i = 0; i < 4; i++)
			f[i] = lane_h[i] ^ byte_sum;
		f = fold_lanes(f);
		for (int i = 0; i < 4; i++)
			f[i] = avalanche(f[i]);
		hashes_due.push_back(fold_lanes(f));
		mid_msg = 1'b0;
		word_slot = '0;
		byte_sum = '0;
	endtask

	// Source side: hold the word until taken, then offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_word(on_bus);
				words_taken++;
			end
			if (!in_valid || in_ready) begin
				if (words_todo.size() != 0 &&
				    $urandom_range(99) >= (pace == PACE_SLOW_SINK ? 34 :
				                            pace == PACE_SLOW_SOURCE ? 76 : 0)) begin
					on_bus = words_todo.pop_front();
					in_valid <= 1'b1;
					data_word <= on_bus.data;
					byte_count <= on_bus.count;
					last <= on_bus.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: compare each digest with the oldest one predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_hash = {hash_word3, hash_word2, hash_word1, hash_word0};
				if (hashes_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected digest, expected none, got %h", $time, got_hash);
				end else begin
					want_hash = hashes_due.pop_front();
					hashes_seen++;
					for (int i = 0; i < 4; i++) begin
						if (want_hash[i] !== got_hash[i]) begin
							fail_count++;
							$display("%0t: hash_word%0d expected %h got %h", $time, i,
							         want_hash[i], got_hash[i]);
						end
					end
				end
			end
			out_ready <= $urandom_range(99) >= (pace == PACE_SLOW_SINK ? 76 :
			                                    pace == PACE_SLOW_SOURCE ? 34 : 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d digests outstanding",
				         $time, quiet, hashes_due.size());
				$display("simulation failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic word_t rand_data();
		int r;
		r = $urandom_range(99);
		if (r < 7)
			return 32'h0;
		if (r < 15)
			return 32'hffffffff;
		return $urandom();
	endfunction

	task automatic queue_word(input word_t d, input logic [2:0] n, input logic f);
		msg_word_t w;
		w.data = d;
		w.count = n;
		w.fin = f;
		words_todo.push_back(w);
	endtask

	// A well-formed message with random content, now and then spoiled by an
	// empty word or a short word before the end.
	task automatic queue_message(input int body);
		int         noise_at;
		int         kind;
		logic [2:0] n;
		noise_at = ($urandom_range(99) < 15) ? $urandom_range(body) : -1;
		kind = $urandom_range(1);
		for (int j = 0; j < body; j++) begin
			if (j == noise_at && kind == 0)
				queue_word(rand_data(), 3'd0, 1'b0);
			n = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
			if (j == noise_at && kind == 1)
				n = 3'($urandom_range(3, 1));
			queue_word(rand_data(), n, 1'b0);
			phase_items++;
		end
		if (noise_at == body && kind == 0)
			queue_word(rand_data(), 3'd0, 1'b0);
		queue_word(rand_data(), 3'($urandom_range(7)), 1'b1);
		phase_items++;
	endtask

	function automatic int msg_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(7);
		if (r < 95)
			return $urandom_range(20, 8);
		return $urandom_range(64, 21);
	endfunction

	// Words with no digest may still be in flight when the last digest lands.
	task wait_idle();
		@(negedge clk);
		while (words_todo.size() != 0 || in_valid || hashes_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task write_seed(input word_t v);
		@(posedge clk);
		seed_we <= 1'b1;
		seed_wdata <= v;
		seed_val = v;
		@(posedge clk);
		seed_we <= 1'b0;
		seeds_written++;
	endtask

	initial begin
		word_t s;
		@(posedge arst_n);
		@(posedge clk);
		write_seed(32'h0);

		// empty message, then one byte with garbage above it, then one zero word
		queue_word(32'hdeadbeef, 3'd0, 1'b1);
		queue_word(32'hffffffff, 3'd1, 1'b1);
		queue_word(32'h00000000, 3'd4, 1'b1);
		// empty word skipped, short word mid-message, oversize counts, full last word
		queue_word(32'hffffffff, 3'd4, 1'b0);
		queue_word(32'h12345678, 3'd0, 1'b0);
		queue_word(32'hffffffff, 3'd2, 1'b0);
		queue_word(32'ha5a5a5a5, 3'd5, 1'b0);
		queue_word(32'h5a5a5a5a, 3'd6, 1'b1);
		// partial last word in the fourth slot
		queue_word(32'hffffffff, 3'd7, 1'b0);
		queue_word(32'hffffffff, 3'd7, 1'b0);
		queue_word(32'hffffffff, 3'd7, 1'b0);
		queue_word(32'hffffffff, 3'd3, 1'b1);
		// whole block, then an empty last word
		repeat (4) queue_word(32'h01020304, 3'd4, 1'b0);
		queue_word(32'h00000000, 3'd0, 1'b1);
		// last word in the second slot
		queue_word(32'h80000000, 3'd4, 1'b0);
		queue_word(32'h00000001, 3'd1, 1'b1);

		for (int p = 1; p <= 6; p++) begin
			wait_idle();
			pace = (p < 3) ? PACE_SLOW_SINK : (p < 5) ? PACE_SLOW_SOURCE : PACE_FREE;
			case (p)
				1: s = 32'hffffffff;
				3: s = 32'h80000000;
				5: s = 32'h0;
				default: s = $urandom();
			endcase
			write_seed(s);
			phase_items = 0;
			while (phase_items < PHASE_WORDS)
				queue_message(msg_len());
		end
		wait_idle();

		$display("Hashed %0d words into %0d digests under %0d seed values,", words_taken,
		         hashes_seen, seeds_written);
		$display("with sink stalls, source stalls and full-rate streaming.");
		if (fail_count == 0 && hashes_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
